// ===== rtl/core/mpfw_pkg.sv =====
// shared types and constants of the monochrome page frame store writer
package mpfw_pkg;

    localparam int PANEL_COLUMNS = 128;
    localparam int PANEL_PAGES   = 8;
    localparam int ROWS_PER_PAGE = 8;
    localparam int COL_W         = $clog2(PANEL_COLUMNS);
    localparam int PAGE_W        = $clog2(PANEL_PAGES);
    localparam int ROW_W         = PAGE_W + $clog2(ROWS_PER_PAGE);
    localparam int STORE_DEPTH   = PANEL_COLUMNS * PANEL_PAGES;
    localparam int ADDR_W        = $clog2(STORE_DEPTH);
    localparam logic [7:0] PIXEL_LSB = 8'h01;

    typedef enum logic [2:0] {
        REQ_WINDOW = 3'd0,
        REQ_STREAM = 3'd1,
        REQ_POINT  = 3'd2,
        REQ_FINISH = 3'd3,
        REQ_READ   = 3'd4
    } req_t;

    typedef enum logic [1:0] {
        KIND_UPDATE = 2'd0,
        KIND_READ   = 2'd1,
        KIND_BOX    = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        CFG_PORTRAIT = 2'd0,
        CFG_WIDTH    = 2'd1,
        CFG_HEIGHT   = 2'd2
    } cfg_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } state_t;

    // input payload, last declared field in the lowest bits
    typedef struct packed {
        logic [2:0] pad;
        logic [6:0] read_column;
        logic [2:0] read_page;
        logic       pixel_black;
        logic [6:0] pos_y;
        logic [6:0] pos_x;
        logic [6:0] win_y1;
        logic [6:0] win_y0;
        logic [6:0] win_x1;
        logic [6:0] win_x0;
    } in_data_t;

    // result payload, last declared field in the lowest bits
    typedef struct packed {
        logic       pad;
        logic [6:0] box_row_last;
        logic [6:0] box_row_first;
        logic [6:0] box_col_last;
        logic [6:0] box_col_first;
        logic       box_empty;
        logic [7:0] data_byte;
        logic [6:0] column;
        logic [2:0] page;
    } out_data_t;

    typedef struct packed {
        logic clear_wr;
        logic accept;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic need_result;
        logic out_free;
    } sts_t;

endpackage

// ===== rtl/core/mpfw_ram.sv =====
// generic single write port ram with registered read
module mpfw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/core/mpfw_ctrl.sv =====
// controller: clearing pass, item accept and read-modify-write sequencing
module mpfw_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  mpfw_pkg::sts_t sts,
    output mpfw_pkg::cmd_t cmd
);

    mpfw_pkg::state_t state_reg;
    mpfw_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mpfw_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mpfw_pkg::ST_CLEAR:
            begin
                if (sts.clear_last)
                begin
                    state_next = mpfw_pkg::ST_IDLE;
                end
            end
            mpfw_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = mpfw_pkg::ST_EXEC;
                end
            end
            mpfw_pkg::ST_EXEC:
            begin
                if (!sts.need_result || sts.out_free)
                begin
                    state_next = mpfw_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mpfw_pkg::ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            mpfw_pkg::ST_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
            end
            mpfw_pkg::ST_IDLE:
            begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            mpfw_pkg::ST_EXEC:
            begin
                // hold the item until the result register can take it
                cmd.commit = !sts.need_result || sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== rtl/core/mpfw_datapath.sv =====
// datapath: configuration, cursor, pixel mapping, frame store, dirty box, result register
module mpfw_datapath (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_we,
    input  logic [1:0]     cfg_index,
    input  logic [7:0]     cfg_data,
    input  logic [55:0]    s_tdata,
    input  logic [2:0]     s_tuser,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [47:0]    m_tdata,
    output logic [1:0]     m_tuser,
    input  mpfw_pkg::cmd_t cmd,
    output mpfw_pkg::sts_t sts
);

    localparam int AW = mpfw_pkg::ADDR_W;

    mpfw_pkg::in_data_t din;
    mpfw_pkg::req_t     req;

    // configuration
    logic       portrait_reg;
    logic [7:0] width_reg;
    logic [7:0] height_reg;

    // cursor and window
    logic [6:0] cur_x_reg, cur_x_next;
    logic [6:0] cur_y_reg, cur_y_next;
    logic [6:0] win_l_reg, win_l_next;
    logic [6:0] win_r_reg, win_r_next;
    logic [6:0] win_t_reg, win_t_next;
    logic [6:0] win_b_reg, win_b_next;

    // item under way
    mpfw_pkg::req_t                  kind_reg, kind_next;
    logic                            black_reg, black_next;
    logic                            hit_reg, hit_next;
    logic                            need_reg, need_next;
    logic [AW-1:0]                   addr_reg, addr_next;
    logic [7:0]                      mask_reg, mask_next;
    logic [mpfw_pkg::ROW_W-1:0]      row_reg, row_next;

    // dirty box
    logic       dirty_reg, dirty_next;
    logic [6:0] col_first_reg, col_first_next;
    logic [6:0] col_last_reg, col_last_next;
    logic [6:0] row_first_reg, row_first_next;
    logic [6:0] row_last_reg, row_last_next;

    // clearing pass
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;

    // result register
    logic                 m_valid_reg, m_valid_next;
    mpfw_pkg::out_data_t  out_reg, out_next;
    mpfw_pkg::kind_t      okind_reg, okind_next;

    // store port
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic [7:0]    ram_rdata;

    // pixel mapping
    logic [6:0] px_x, px_y, px_col;
    logic [7:0] px_row;
    logic       px_hit;
    logic [7:0] new_byte;
    logic [6:0] hit_col, hit_row;

    function automatic logic [7:0] PIXEL_LSB_SHIFT(input logic [2:0] bit_sel);
        PIXEL_LSB_SHIFT = mpfw_pkg::PIXEL_LSB << bit_sel;
    endfunction

    assign din = mpfw_pkg::in_data_t'(s_tdata);
    assign req = mpfw_pkg::req_t'(s_tuser);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            portrait_reg <= 1'b0;
            width_reg    <= 8'd128;
            height_reg   <= 8'd64;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mpfw_pkg::CFG_PORTRAIT: portrait_reg <= cfg_data[0];
                mpfw_pkg::CFG_WIDTH:    width_reg    <= cfg_data;
                mpfw_pkg::CFG_HEIGHT:   height_reg   <= cfg_data;
                default:                portrait_reg <= portrait_reg;
            endcase
        end
    end

    // coordinate to store byte and bit
    always_comb
    begin
        px_x = (req == mpfw_pkg::REQ_STREAM) ? cur_x_reg : din.pos_x;
        px_y = (req == mpfw_pkg::REQ_STREAM) ? cur_y_reg : din.pos_y;
        if (portrait_reg)
        begin
            px_col = px_y;
            px_row = width_reg - 8'd1 - {1'b0, px_x};
        end
        else
        begin
            px_col = px_x;
            px_row = {1'b0, px_y};
        end
        px_hit = ({1'b0, px_x} < width_reg) && ({1'b0, px_y} < height_reg)
              && ({3'd0, px_row[7:3]} < 8'(mpfw_pkg::PANEL_PAGES))
              && ({1'b0, px_col} < 8'(mpfw_pkg::PANEL_COLUMNS));
    end

    assign new_byte = black_reg ? (ram_rdata | mask_reg) : (ram_rdata & ~mask_reg);
    assign hit_col  = 7'(addr_reg[mpfw_pkg::COL_W-1:0]);
    assign hit_row  = 7'(row_reg);

    always_comb
    begin
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        win_l_next     = win_l_reg;
        win_r_next     = win_r_reg;
        win_t_next     = win_t_reg;
        win_b_next     = win_b_reg;
        kind_next      = kind_reg;
        black_next     = black_reg;
        hit_next       = hit_reg;
        need_next      = need_reg;
        addr_next      = addr_reg;
        mask_next      = mask_reg;
        row_next       = row_reg;
        dirty_next     = dirty_reg;
        col_first_next = col_first_reg;
        col_last_next  = col_last_reg;
        row_first_next = row_first_reg;
        row_last_next  = row_last_reg;
        clr_cnt_next   = clr_cnt_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        out_next       = out_reg;
        okind_next     = okind_reg;
        ram_we         = 1'b0;
        ram_waddr      = addr_reg;
        ram_wdata      = new_byte;

        if (cmd.clear_wr)
        begin
            ram_we       = 1'b1;
            ram_waddr    = clr_cnt_reg;
            ram_wdata    = '0;
            clr_cnt_next = clr_cnt_reg + 1'b1;
        end

        if (cmd.accept)
        begin
            kind_next  = req;
            black_next = din.pixel_black;
            hit_next   = px_hit;
            mask_next  = PIXEL_LSB_SHIFT(px_row[2:0]);
            row_next   = mpfw_pkg::ROW_W'(px_row);
            if (req == mpfw_pkg::REQ_READ)
            begin
                addr_next = {mpfw_pkg::PAGE_W'(din.read_page),
                             mpfw_pkg::COL_W'(din.read_column)};
            end
            else
            begin
                addr_next = {mpfw_pkg::PAGE_W'(px_row[7:3]), mpfw_pkg::COL_W'(px_col)};
            end
            case (req)
                mpfw_pkg::REQ_WINDOW:
                begin
                    need_next  = 1'b0;
                    win_l_next = din.win_x0;
                    win_r_next = din.win_x1;
                    win_t_next = din.win_y0;
                    win_b_next = din.win_y1;
                    cur_x_next = din.win_x0;
                    cur_y_next = din.win_y0;
                end
                mpfw_pkg::REQ_STREAM, mpfw_pkg::REQ_POINT:
                begin
                    need_next = px_hit;
                end
                mpfw_pkg::REQ_FINISH, mpfw_pkg::REQ_READ:
                begin
                    need_next = 1'b1;
                end
                default:
                begin
                    need_next = 1'b0;
                end
            endcase
        end

        if (cmd.commit)
        begin
            out_next     = '0;
            m_valid_next = (m_valid_reg && !m_tready) || need_reg;
            case (kind_reg)
                mpfw_pkg::REQ_STREAM, mpfw_pkg::REQ_POINT:
                begin
                    if (hit_reg)
                    begin
                        ram_we           = 1'b1;
                        okind_next       = mpfw_pkg::KIND_UPDATE;
                        out_next.page    = 3'(addr_reg[AW-1:mpfw_pkg::COL_W]);
                        out_next.column  = hit_col;
                        out_next.data_byte = new_byte;
                        dirty_next       = 1'b1;
                        if (!dirty_reg)
                        begin
                            col_first_next = hit_col;
                            col_last_next  = hit_col;
                            row_first_next = hit_row;
                            row_last_next  = hit_row;
                        end
                        else
                        begin
                            if (hit_col < col_first_reg) col_first_next = hit_col;
                            if (hit_col > col_last_reg)  col_last_next  = hit_col;
                            if (hit_row < row_first_reg) row_first_next = hit_row;
                            if (hit_row > row_last_reg)  row_last_next  = hit_row;
                        end
                    end
                    if (kind_reg == mpfw_pkg::REQ_STREAM)
                    begin
                        // raster walk inside the window
                        if (cur_x_reg >= win_r_reg)
                        begin
                            cur_x_next = win_l_reg;
                            cur_y_next = (cur_y_reg >= win_b_reg) ? win_t_reg
                                                                  : cur_y_reg + 7'd1;
                        end
                        else
                        begin
                            cur_x_next = cur_x_reg + 7'd1;
                        end
                    end
                end
                mpfw_pkg::REQ_FINISH:
                begin
                    okind_next         = mpfw_pkg::KIND_BOX;
                    out_next.box_empty = !dirty_reg;
                    if (dirty_reg)
                    begin
                        out_next.box_col_first = col_first_reg;
                        out_next.box_col_last  = col_last_reg;
                        out_next.box_row_first = row_first_reg;
                        out_next.box_row_last  = row_last_reg;
                    end
                    dirty_next     = 1'b0;
                    col_first_next = '0;
                    col_last_next  = '0;
                    row_first_next = '0;
                    row_last_next  = '0;
                end
                mpfw_pkg::REQ_READ:
                begin
                    okind_next         = mpfw_pkg::KIND_READ;
                    out_next.page      = 3'(addr_reg[AW-1:mpfw_pkg::COL_W]);
                    out_next.column    = hit_col;
                    out_next.data_byte = ram_rdata;
                end
                default:
                begin
                    out_next = out_reg;
                end
            endcase
            if (!need_reg)
            begin
                out_next = out_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            win_l_reg     <= '0;
            win_r_reg     <= '0;
            win_t_reg     <= '0;
            win_b_reg     <= '0;
            dirty_reg     <= 1'b0;
            col_first_reg <= '0;
            col_last_reg  <= '0;
            row_first_reg <= '0;
            row_last_reg  <= '0;
            clr_cnt_reg   <= '0;
            need_reg      <= 1'b0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            cur_x_reg     <= cur_x_next;
            cur_y_reg     <= cur_y_next;
            win_l_reg     <= win_l_next;
            win_r_reg     <= win_r_next;
            win_t_reg     <= win_t_next;
            win_b_reg     <= win_b_next;
            dirty_reg     <= dirty_next;
            col_first_reg <= col_first_next;
            col_last_reg  <= col_last_next;
            row_first_reg <= row_first_next;
            row_last_reg  <= row_last_next;
            clr_cnt_reg   <= clr_cnt_next;
            need_reg      <= need_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        black_reg <= black_next;
        hit_reg   <= hit_next;
        addr_reg  <= addr_next;
        mask_reg  <= mask_next;
        row_reg   <= row_next;
        out_reg   <= out_next;
        okind_reg <= okind_next;
    end

    mpfw_ram #(
        .WIDTH (8),
        .DEPTH (mpfw_pkg::STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.accept),
        .raddr (addr_next),
        .rdata (ram_rdata)
    );

    assign sts.clear_last  = (clr_cnt_reg == {AW{1'b1}});
    assign sts.need_result = need_reg;
    assign sts.out_free    = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = out_reg;
    assign m_tuser  = okind_reg;

endmodule

// ===== rtl/core/mono_page_framebuffer_writer_core.sv =====
// top level of the monochrome page frame store writer
// Frame store of a 1 bit per pixel panel held as 8 pages of 8 rows by 128 columns in a
// synchronous ram. After reset the block zeroes the store, one byte a cycle, with
// s_tready low; configuration writes are taken during that pass. Each item then has a
// transfer cycle, which reads the addressed store byte, and an execute state, which
// modifies and writes it back, updates cursor and dirty box and loads the result
// register; this read-modify-write on the single store port sets the rate. When the
// result register still holds an untaken result, an item that has a result waits in the
// execute state until the register frees.
module mono_page_framebuffer_writer_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // win_x0, win_x1, win_y0, win_y1, pos_x, pos_y, pixel_black, read_page, read_column
    input  logic [55:0] s_tdata,
    // req_type
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // page, column, data_byte, box_empty, box_col_first, box_col_last,
    // box_row_first, box_row_last
    output logic [47:0] m_tdata,
    // result_kind
    output logic [1:0]  m_tuser
);

    mpfw_pkg::cmd_t cmd;
    mpfw_pkg::sts_t sts;

    mpfw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    mpfw_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .sts       (sts)
    );

    // no transfer while the store is being cleared
    assert property (@(posedge clk) disable iff (!rst_n) cmd.clear_wr |-> !s_tready)
        else $error("input taken during clearing pass");

    // one item at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second item taken before first finished");

    // a result is only loaded into a free result register
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && sts.need_result) |-> sts.out_free)
        else $error("result register overwritten");

    // a committed item with a result shows it next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && sts.need_result) |=> m_tvalid)
        else $error("result lost");

endmodule

// ===== verif/tb.sv =====
// testbench for the page frame store writer: directed and random requests checked against a model
module tb;

    localparam int          PHASES       = 8;
    localparam int          PHASE_ITEMS  = 166;
    localparam int          LONG_HOLD    = 300;
    localparam int          SETTLE       = 4;
    localparam int          QUIET_LIMIT  = 4000;
    localparam logic [2:0]  REQ_CODE_MAX = 3'h7;

    typedef struct packed {
        mpfw_pkg::kind_t     kind;
        mpfw_pkg::out_data_t data;
    } result_t;

    // behavioural copy of the frame store with its queue of awaited results
    class frame_model;
        bit [7:0]    store [mpfw_pkg::STORE_DEPTH];
        bit          portrait;
        int unsigned pan_w, pan_h;
        bit [6:0]    cur_x, cur_y, win_l, win_r, win_t, win_b;
        bit          dirty;
        int unsigned col_lo, col_hi, row_lo, row_hi;
        result_t     awaited[$];
        int          errors;
        int          tally [3];

        function new();
            pan_w = 128;
            pan_h = 64;
        endfunction

        function void set_reg(logic [1:0] idx, logic [7:0] v);
            case (idx)
                mpfw_pkg::CFG_PORTRAIT: portrait = v[0];
                mpfw_pkg::CFG_WIDTH:    pan_w = {24'd0, v};
                mpfw_pkg::CFG_HEIGHT:   pan_h = {24'd0, v};
                default: ;
            endcase
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function bit plot(int unsigned x, int unsigned y, bit black, output result_t r);
            int unsigned col, row, pg, idx;
            r = '0;
            if (x >= pan_w || y >= pan_h)
                return 0;
            if (portrait)
            begin
                col = y;
                row = pan_w - 1 - x;
            end
            else
            begin
                col = x;
                row = y;
            end
            pg = row / mpfw_pkg::ROWS_PER_PAGE;
            if (pg >= mpfw_pkg::PANEL_PAGES || col >= mpfw_pkg::PANEL_COLUMNS)
                return 0;
            idx = pg * mpfw_pkg::PANEL_COLUMNS + col;
            store[idx][row % mpfw_pkg::ROWS_PER_PAGE] = black;
            if (!dirty)
            begin
                dirty = 1;
                col_lo = col;
                col_hi = col;
                row_lo = row;
                row_hi = row;
            end
            else
            begin
                if (col < col_lo) col_lo = col;
                if (col > col_hi) col_hi = col;
                if (row < row_lo) row_lo = row;
                if (row > row_hi) row_hi = row;
            end
            r.kind = mpfw_pkg::KIND_UPDATE;
            r.data.page = 3'(pg);
            r.data.column = 7'(col);
            r.data.data_byte = store[idx];
            return 1;
        endfunction

        function void note_request(logic [2:0] req, mpfw_pkg::in_data_t d);
            result_t r;
            bit      got;
            r = '0;
            got = 0;
            case (req)
                mpfw_pkg::REQ_WINDOW:
                begin
                    win_l = d.win_x0;
                    win_r = d.win_x1;
                    win_t = d.win_y0;
                    win_b = d.win_y1;
                    cur_x = win_l;
                    cur_y = win_t;
                end
                mpfw_pkg::REQ_STREAM:
                begin
                    got = plot(cur_x, cur_y, d.pixel_black, r);
                    // cursor walks the window even when the pixel is off the panel
                    if (cur_x >= win_r)
                    begin
                        cur_x = win_l;
                        cur_y = (cur_y >= win_b) ? win_t : cur_y + 7'd1;
                    end
                    else
                        cur_x = cur_x + 7'd1;
                end
                mpfw_pkg::REQ_POINT:
                    got = plot(d.pos_x, d.pos_y, d.pixel_black, r);
                mpfw_pkg::REQ_FINISH:
                begin
                    r.kind = mpfw_pkg::KIND_BOX;
                    if (dirty)
                    begin
                        r.data.box_col_first = 7'(col_lo);
                        r.data.box_col_last  = 7'(col_hi);
                        r.data.box_row_first = 7'(row_lo);
                        r.data.box_row_last  = 7'(row_hi);
                    end
                    else
                        r.data.box_empty = 1'b1;
                    dirty = 0;
                    col_lo = 0;
                    col_hi = 0;
                    row_lo = 0;
                    row_hi = 0;
                    got = 1;
                end
                mpfw_pkg::REQ_READ:
                begin
                    r.kind = mpfw_pkg::KIND_READ;
                    r.data.page = d.read_page;
                    r.data.column = d.read_column;
                    r.data.data_byte =
                        store[d.read_page * mpfw_pkg::PANEL_COLUMNS + d.read_column];
                    got = 1;
                end
                default: ;
            endcase
            if (got)
                awaited.push_back(r);
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            end
        endfunction

        function void check_result(logic [1:0] kind, mpfw_pkg::out_data_t got);
            result_t want;
            if (awaited.size() == 0)
            begin
                errors++;
                $display("%0t: result of kind %0d with nothing awaited", $time, kind);
                return;
            end
            want = awaited.pop_front();
            tally[want.kind]++;
            compare_field("result_kind", 8'(want.kind), 8'(kind));
            compare_field("page", 8'(want.data.page), 8'(got.page));
            compare_field("column", 8'(want.data.column), 8'(got.column));
            compare_field("data_byte", want.data.data_byte, got.data_byte);
            compare_field("box_empty", 8'(want.data.box_empty), 8'(got.box_empty));
            compare_field("box_col_first", 8'(want.data.box_col_first),
                          8'(got.box_col_first));
            compare_field("box_col_last", 8'(want.data.box_col_last),
                          8'(got.box_col_last));
            compare_field("box_row_first", 8'(want.data.box_row_first),
                          8'(got.box_row_first));
            compare_field("box_row_last", 8'(want.data.box_row_last),
                          8'(got.box_row_last));
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [7:0]  cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic [1:0]  m_tuser;

    frame_model fb = new();

    int burst_left;
    int sent_items;
    int ignored_items;
    int settings_used;
    int quiet;
    bit long_hold;
    bit mid_pause_done;
    bit cur_portrait;
    int cur_w;
    int cur_h;
    int phase;
    int target;

    // 0 in the width or height table picks a random size
    int cfg_p [PHASES] = '{1, 0, 1, 0, 1, 0, 1, 0};
    int cfg_w [PHASES] = '{64, 1, 128, 128, 1, 128, 0, 0};
    int cfg_h [PHASES] = '{128, 1, 128, 128, 128, 1, 0, 0};

    mono_page_framebuffer_writer_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // results are checked before the new transfer is noted
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            fb.check_result(m_tuser, mpfw_pkg::out_data_t'(m_tdata));
        if (rst_n && s_tvalid && s_tready)
            fb.note_request(s_tuser, mpfw_pkg::in_data_t'(s_tdata));
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet <= 0;
        else if (quiet >= QUIET_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

    // receiver: stall pattern in chunks, plus one long hold-off on request
    initial
    begin
        int mode;
        int chunk;
        chunk = 0;
        mode = 0;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold)
            begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge clk);
                long_hold = 0;
            end
            else
            begin
                if (chunk == 0)
                begin
                    mode = $urandom_range(0, 3);
                    chunk = $urandom_range(8, 80);
                end
                chunk--;
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= ($urandom_range(0, 1) != 0);
                    2:       m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    function automatic mpfw_pkg::in_data_t noise();
        logic [63:0]        raw;
        mpfw_pkg::in_data_t d;
        raw = {$urandom, $urandom};
        d = raw[55:0];
        d.pad = '0;
        return d;
    endfunction

    function automatic mpfw_pkg::in_data_t mk_window(int x0, int x1, int y0, int y1);
        mpfw_pkg::in_data_t d;
        d = noise();
        d.win_x0 = 7'(x0);
        d.win_x1 = 7'(x1);
        d.win_y0 = 7'(y0);
        d.win_y1 = 7'(y1);
        return d;
    endfunction

    function automatic mpfw_pkg::in_data_t mk_pixel(bit black);
        mpfw_pkg::in_data_t d;
        d = noise();
        d.pixel_black = black;
        return d;
    endfunction

    function automatic mpfw_pkg::in_data_t mk_point(int x, int y, bit black);
        mpfw_pkg::in_data_t d;
        d = mk_pixel(black);
        d.pos_x = 7'(x);
        d.pos_y = 7'(y);
        return d;
    endfunction

    function automatic mpfw_pkg::in_data_t mk_read(int pg, int col);
        mpfw_pkg::in_data_t d;
        d = noise();
        d.read_page = 3'(pg);
        d.read_column = 7'(col);
        return d;
    endfunction

    // mostly on or just past the panel, sometimes anywhere
    function automatic int near(int size);
        int top;
        top = (size > 127) ? 127 : size;
        if ($urandom_range(0, 3) != 0)
            return $urandom_range(0, top);
        return $urandom_range(0, 127);
    endfunction

    task automatic idle(int n);
        @(negedge clk);
        s_tvalid <= 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    task automatic send_item(logic [2:0] req, mpfw_pkg::in_data_t d);
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= d;
        do @(posedge clk); while (!s_tready);
        if (req <= mpfw_pkg::REQ_READ)
            sent_items++;
        else
            ignored_items++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 40);
            idle($urandom_range(1, 12));
        end
    endtask

    task automatic drain();
        idle(1);
        while (fb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [7:0] v);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        fb.set_reg(idx, v);
    endtask

    task automatic set_panel(bit p, int w, int h);
        drain();
        cur_portrait = p;
        cur_w = w;
        cur_h = h;
        cfg_write(mpfw_pkg::CFG_PORTRAIT, {7'd0, p});
        cfg_write(mpfw_pkg::CFG_WIDTH, 8'(w));
        cfg_write(mpfw_pkg::CFG_HEIGHT, 8'(h));
        @(negedge clk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic directed_items();
        send_item(mpfw_pkg::REQ_FINISH, noise());
        send_item(mpfw_pkg::REQ_READ, mk_read(7, 127));
        // corner window: wraps at the right edge and back to the top
        send_item(mpfw_pkg::REQ_WINDOW, mk_window(126, 127, 62, 63));
        repeat (5) send_item(mpfw_pkg::REQ_STREAM, mk_pixel(1'b1));
        send_item(mpfw_pkg::REQ_POINT, mk_point(0, 0, 1'b1));
        send_item(mpfw_pkg::REQ_POINT, mk_point(127, 63, 1'b1));
        send_item(mpfw_pkg::REQ_POINT, mk_point(127, 64, 1'b1));
        send_item(mpfw_pkg::REQ_POINT, mk_point(0, 127, 1'b1));
        send_item(mpfw_pkg::REQ_POINT, mk_point(0, 0, 1'b0));
        // left beyond right steps a row per pixel
        send_item(mpfw_pkg::REQ_WINDOW, mk_window(10, 3, 0, 1));
        repeat (3) send_item(mpfw_pkg::REQ_STREAM, mk_pixel(1'b1));
        send_item(3'(mpfw_pkg::REQ_READ + 3'd1), noise());
        send_item(REQ_CODE_MAX, noise());
        send_item(mpfw_pkg::REQ_READ, mk_read(0, 0));
        send_item(mpfw_pkg::REQ_READ, mk_read(7, 127));
        send_item(mpfw_pkg::REQ_FINISH, noise());
        send_item(mpfw_pkg::REQ_FINISH, noise());
    endtask

    task automatic random_item();
        int op;
        int x0;
        int x1;
        int y0;
        int y1;
        op = $urandom_range(0, 99);
        if (op < 10)
        begin
            x0 = near(cur_w);
            y0 = near(cur_h);
            if ($urandom_range(0, 7) == 0)
                x1 = $urandom_range(0, 127);
            else
                x1 = (x0 + $urandom_range(0, 9) > 127) ? 127 : x0 + $urandom_range(0, 9);
            if ($urandom_range(0, 7) == 0)
                y1 = $urandom_range(0, 127);
            else
                y1 = (y0 + $urandom_range(0, 9) > 127) ? 127 : y0 + $urandom_range(0, 9);
            send_item(mpfw_pkg::REQ_WINDOW, mk_window(x0, x1, y0, y1));
            repeat ($urandom_range(1, 24))
                send_item(mpfw_pkg::REQ_STREAM, mk_pixel($urandom_range(0, 2) != 0));
        end
        else if (op < 35)
            send_item(mpfw_pkg::REQ_POINT,
                      mk_point(near(cur_w), near(cur_h), $urandom_range(0, 2) != 0));
        else if (op < 50)
            send_item(mpfw_pkg::REQ_READ,
                      mk_read($urandom_range(0, 7), near(cur_portrait ? cur_h : cur_w)));
        else if (op < 58)
            send_item(mpfw_pkg::REQ_FINISH, noise());
        else if (op < 61)
            send_item(3'($urandom_range(mpfw_pkg::REQ_READ + 1, REQ_CODE_MAX)), noise());
        else
            send_item(mpfw_pkg::REQ_STREAM, mk_pixel($urandom_range(0, 2) != 0));
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        quiet     = 0;
        burst_left = $urandom_range(0, 40);
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        set_panel(1'b0, 128, 64);
        directed_items();

        for (phase = 0; phase < PHASES; phase++)
        begin
            set_panel(cfg_p[phase] != 0,
                      cfg_w[phase] == 0 ? $urandom_range(1, 128) : cfg_w[phase],
                      cfg_h[phase] == 0 ? $urandom_range(1, 128) : cfg_h[phase]);
            // block fills up and stalls its input while results are held off
            if (phase == 0)
                long_hold = 1;
            target = sent_items + PHASE_ITEMS;
            while (sent_items < target)
            begin
                if (phase == 3 && !mid_pause_done && sent_items >= target - PHASE_ITEMS / 2)
                begin
                    drain();
                    mid_pause_done = 1;
                end
                random_item();
            end
        end

        drain();
        repeat (8) @(posedge clk);
        $display("covered %0d requests and %0d ignored codes over %0d panel settings",
                 sent_items, ignored_items, settings_used);
        $display("checked %0d byte updates, %0d reads and %0d box reports",
                 fb.tally[mpfw_pkg::KIND_UPDATE], fb.tally[mpfw_pkg::KIND_READ],
                 fb.tally[mpfw_pkg::KIND_BOX]);
        if (fb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
